@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the averager RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SWA_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// condition must never be seen outside reset
`define SWA_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

@@ rtl/core/swa_pkg.sv @@
// ----------------------------------------------------------------------------
// swa_pkg
// Widths, limits and register map of the stable window averager.
// ----------------------------------------------------------------------------
`default_nettype none

package swa_pkg;

   localparam int CHANNELS   = 4;
   localparam int MAX_WINDOW = 128;

   localparam int CH_W      = 2;
   localparam int SAMPLE_W  = 16;
   localparam int TOL_W     = 16;
   localparam int WIN_W     = 8;
   localparam int AVG_W     = 13;
   localparam int POWER_W   = 2 * AVG_W;

   localparam int COUNT_W   = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W     = SAMPLE_W + $clog2(MAX_WINDOW);
   localparam int DIVIDEND_W = SUM_W + 1;
   localparam int FIVE_W    = $clog2(5 * MAX_WINDOW + 1);
   localparam int DIVISOR_W = $clog2(10 * MAX_WINDOW + 1);
   localparam int REM_W     = DIVISOR_W + 1;
   localparam int ITER_W    = $clog2(AVG_W);

   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = CH_W;
   localparam int RSP_DATA_W = ((AVG_W + POWER_W + 7) / 8) * 8;
   localparam int RSP_USER_W = CH_W + 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = TOL_W;

   // register map: tolerances first, then window lengths
   localparam logic [CSR_ADDR_W-1:0] REG_TOL_BASE = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_WIN_BASE = 3'd4;

   localparam logic [TOL_W-1:0] TOL_RST [CHANNELS] = '{16'd10, 16'd50, 16'd10, 16'd10};
   localparam logic [WIN_W-1:0] WIN_RST [CHANNELS] = '{8'd10, 8'd10, 8'd100, 8'd10};

   localparam logic [CH_W-1:0] CH_VOUT = 2'd1;
   localparam logic [CH_W-1:0] CH_IOUT = 2'd2;

endpackage

`default_nettype wire

@@ rtl/core/stable_window_averager_top.sv @@
// ----------------------------------------------------------------------------
// stable_window_averager_top
// Four-channel stability-qualified averager with output power product.
// ----------------------------------------------------------------------------
// Each request word carries a channel (tuser) and a sample in hundredths
// (tdata); each one yields exactly one response word. A sample that steps
// further than the channel tolerance from the last accepted one drops the
// window; when a window fills its mean is stored in tenths, rounded half up,
// and the product of the channel 1 and channel 2 averages is reported.
// The response word is registered on leaving the done state. A request
// passes the check, multiply and done states, and one that closes a window
// also the divide state, where one shared restoring divider resolves the
// mean one quotient bit per cycle. The next request is taken once the block
// is back in idle. A held response stalls the block only when the next word
// is also finished and waiting. req_tready is high only while no word is in
// work; a finished response may wait in its output register while the next
// request is taken. Tolerance and window registers are to be written by the
// user through the csr port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stable_window_averager_top
   import swa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // sample
   input  wire logic [REQ_USER_W-1:0] req_tuser,  // channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // average, power, zero fill
   output logic [RSP_USER_W-1:0]      rsp_tuser,  // out_channel, average_new,
                                                  // window_dropped
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [CH_W-1:0]     ch_ff, ch_in;
   logic [SAMPLE_W-1:0] smp_ff, smp_in;
   logic                fresh_ff, fresh_in;
   logic                drop_ff, drop_in;

   logic [TOL_W-1:0]    tol_ff  [CHANNELS];
   logic [TOL_W-1:0]    tol_in  [CHANNELS];
   logic [WIN_W-1:0]    win_ff  [CHANNELS];
   logic [WIN_W-1:0]    win_in  [CHANNELS];
   logic [SAMPLE_W-1:0] last_ff [CHANNELS];
   logic [SAMPLE_W-1:0] last_in [CHANNELS];
   logic [COUNT_W-1:0]  fill_ff [CHANNELS];
   logic [COUNT_W-1:0]  fill_in [CHANNELS];
   logic [SUM_W-1:0]    sum_ff  [CHANNELS];
   logic [SUM_W-1:0]    sum_in  [CHANNELS];
   logic [AVG_W-1:0]    avg_ff  [CHANNELS];
   logic [AVG_W-1:0]    avg_in  [CHANNELS];

   // shared divider
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [AVG_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] dvs_ff, dvs_in;
   logic [ITER_W-1:0]    iter_ff, iter_in;

   logic [POWER_W-1:0]  power_ff, power_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]     rsp_ch_ff, rsp_ch_in;
   logic [AVG_W-1:0]    rsp_avg_ff, rsp_avg_in;
   logic                rsp_fresh_ff, rsp_fresh_in;
   logic                rsp_drop_ff, rsp_drop_in;
   logic [POWER_W-1:0]  rsp_power_ff, rsp_power_in;

   // per-word datapath
   logic [COUNT_W-1:0]    win_sat;
   logic [SAMPLE_W-1:0]   prev;
   logic [SAMPLE_W-1:0]   diff;
   logic [COUNT_W-1:0]    n_next;
   logic [SUM_W-1:0]      sum_next;
   logic [FIVE_W-1:0]     five_n;
   logic [DIVIDEND_W-1:0] dividend;
   logic [REM_W-1:0]      rem_shift;
   logic                  rem_ge;

   always_comb begin
      if (win_ff[ch_ff] < WIN_W'(2)) begin
         win_sat = COUNT_W'(2);
      end else if (32'(win_ff[ch_ff]) > MAX_WINDOW) begin
         win_sat = COUNT_W'(MAX_WINDOW);
      end else begin
         win_sat = COUNT_W'(win_ff[ch_ff]);
      end
      prev     = last_ff[ch_ff];
      diff     = (prev > smp_ff) ? (prev - smp_ff) : (smp_ff - prev);
      n_next   = fill_ff[ch_ff] + COUNT_W'(1);
      sum_next = sum_ff[ch_ff] + SUM_W'(smp_ff);
      five_n   = FIVE_W'({n_next, 2'b00}) + FIVE_W'(n_next);
      dividend = DIVIDEND_W'(sum_next) + DIVIDEND_W'(five_n);
      rem_shift = {rem_ff[REM_W-2:0], quo_ff[AVG_W-1]};
      rem_ge    = (rem_shift >= REM_W'(dvs_ff));
   end

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      smp_in       = smp_ff;
      fresh_in     = fresh_ff;
      drop_in      = drop_ff;
      tol_in       = tol_ff;
      win_in       = win_ff;
      last_in      = last_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      avg_in       = avg_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvs_in       = dvs_ff;
      iter_in      = iter_ff;
      power_in     = power_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ch_in    = rsp_ch_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_fresh_in = rsp_fresh_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_power_in = rsp_power_ff;

      if (csr_we) begin
         if (csr_addr < REG_WIN_BASE) begin
            tol_in[CH_W'(csr_addr - REG_TOL_BASE)] = csr_wdata;
         end else begin
            win_in[CH_W'(csr_addr - REG_WIN_BASE)] = csr_wdata[WIN_W-1:0];
         end
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ch_in    = req_tuser;
               smp_in   = req_tdata[SAMPLE_W-1:0];
               fresh_in = 1'b0;
               drop_in  = 1'b0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = ST_MUL;
            if (fill_ff[ch_ff] == '0) begin
               last_in[ch_ff] = smp_ff;
               sum_in[ch_ff]  = SUM_W'(smp_ff);
               fill_in[ch_ff] = COUNT_W'(1);
            end else if (diff <= tol_ff[ch_ff]) begin
               last_in[ch_ff] = smp_ff;
               if (n_next >= win_sat) begin
                  fill_in[ch_ff] = '0;
                  sum_in[ch_ff]  = '0;
                  rem_in   = REM_W'(dividend >> AVG_W);
                  quo_in   = dividend[AVG_W-1:0];
                  dvs_in   = DIVISOR_W'({five_n, 1'b0});
                  iter_in  = ITER_W'(AVG_W - 1);
                  state_in = ST_DIV;
               end else begin
                  fill_in[ch_ff] = n_next;
                  sum_in[ch_ff]  = sum_next;
               end
            end else begin
               fill_in[ch_ff] = '0;
               sum_in[ch_ff]  = '0;
               drop_in        = 1'b1;
            end
         end
         ST_DIV: begin
            rem_in  = rem_ge ? (rem_shift - REM_W'(dvs_ff)) : rem_shift;
            quo_in  = {quo_ff[AVG_W-2:0], rem_ge};
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == '0) begin
               avg_in[ch_ff] = {quo_ff[AVG_W-2:0], rem_ge};
               fresh_in      = 1'b1;
               state_in      = ST_MUL;
            end
         end
         ST_MUL: begin
            power_in = POWER_W'(avg_ff[CH_VOUT]) * POWER_W'(avg_ff[CH_IOUT]);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = ch_ff;
               rsp_avg_in   = avg_ff[ch_ff];
               rsp_fresh_in = fresh_ff;
               rsp_drop_in  = drop_ff;
               rsp_power_in = power_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            tol_ff[i]  <= TOL_RST[i];
            win_ff[i]  <= WIN_RST[i];
            last_ff[i] <= '0;
            fill_ff[i] <= '0;
            sum_ff[i]  <= '0;
            avg_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tol_ff       <= tol_in;
         win_ff       <= win_in;
         last_ff      <= last_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         avg_ff       <= avg_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff        <= ch_in;
      smp_ff       <= smp_in;
      fresh_ff     <= fresh_in;
      drop_ff      <= drop_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dvs_ff       <= dvs_in;
      iter_ff      <= iter_in;
      power_ff     <= power_in;
      rsp_ch_ff    <= rsp_ch_in;
      rsp_avg_ff   <= rsp_avg_in;
      rsp_fresh_ff <= rsp_fresh_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_power_ff <= rsp_power_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_power_ff, rsp_avg_ff});
   assign rsp_tuser  = {rsp_drop_ff, rsp_fresh_ff, rsp_ch_ff};

   `SWA_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE), "response raised outside done state")
   `SWA_NEVER(a_fresh_and_drop, clock, reset, rsp_valid_ff && rsp_fresh_ff && rsp_drop_ff, "window both completed and dropped")
   `SWA_ASSERT(a_div_nonzero, clock, reset, (state_ff == ST_DIV) |-> (dvs_ff != '0), "divider running with zero divisor")
   `SWA_ASSERT(a_rem_bound, clock, reset, (state_ff == ST_DIV) |-> (rem_ff < REM_W'(dvs_ff)), "partial remainder not below divisor")

endmodule

`default_nettype wire

@@ test/stable_window_averager_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_window_averager_checker
// Watches the request, response and csr ports of the averager and predicts
// every response word.
// ----------------------------------------------------------------------------
// It tracks the register writes and keeps its own per-channel window state.
// For each accepted request word it queues the predicted response. Each
// accepted response word is compared field by field with the oldest
// prediction. The mismatch count and the number of outstanding words go to the
// top level.
// ----------------------------------------------------------------------------
module stable_window_averager_checker
   import swa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // sample
   input  wire logic [REQ_USER_W-1:0] req_tuser,   // channel
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,   // average, power, zero fill
   input  wire logic [RSP_USER_W-1:0] rsp_tuser,   // out_channel, average_new,
                                                   // window_dropped
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         mismatches,
   output int                         outstanding
);

   typedef struct packed {
      logic [CH_W-1:0]    chan;
      logic [AVG_W-1:0]   average;
      logic               fresh;
      logic               dropped;
      logic [POWER_W-1:0] power;
   } averager_result_type;

   averager_result_type predicted_results[$];

   logic [TOL_W-1:0]    tolerance [CHANNELS];
   logic [WIN_W-1:0]    window_reg [CHANNELS];
   logic [SAMPLE_W-1:0] prev_sample [CHANNELS];
   int unsigned         fill [CHANNELS];
   int unsigned         window_sum [CHANNELS];
   logic [AVG_W-1:0]    mean [CHANNELS];

   function automatic averager_result_type average_step(input logic [CH_W-1:0] ch,
                                                        input logic [SAMPLE_W-1:0] s);
      averager_result_type r;
      int unsigned diff;
      int unsigned n;
      int unsigned wlen;
      r = '0;
      r.chan = ch;
      if (fill[ch] == 0) begin
         prev_sample[ch] = s;
         window_sum[ch] = 32'(s);
         fill[ch] = 1;
      end else begin
         diff = (prev_sample[ch] > s) ? 32'(prev_sample[ch] - s) : 32'(s - prev_sample[ch]);
         if (diff <= 32'(tolerance[ch])) begin
            prev_sample[ch] = s;
            window_sum[ch] += 32'(s);
            fill[ch] += 1;
            n = fill[ch];
            wlen = 32'(window_reg[ch]);
            if (wlen < 2) wlen = 2;
            if (wlen > MAX_WINDOW) wlen = MAX_WINDOW;
            // window may have been shortened mid-way: close on reach or pass
            if (n >= wlen) begin
               mean[ch] = AVG_W'((window_sum[ch] + 5 * n) / (10 * n));
               fill[ch] = 0;
               window_sum[ch] = 0;
               r.fresh = 1'b1;
            end
         end else begin
            fill[ch] = 0;
            window_sum[ch] = 0;
            r.dropped = 1'b1;
         end
      end
      r.average = mean[ch];
      r.power = POWER_W'(mean[CH_VOUT]) * POWER_W'(mean[CH_IOUT]);
      return r;
   endfunction

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      averager_result_type want;
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            tolerance[i] = TOL_RST[i];
            window_reg[i] = WIN_RST[i];
            prev_sample[i] = '0;
            fill[i] = 0;
            window_sum[i] = 0;
            mean[i] = '0;
         end
         predicted_results.delete();
         mismatches = 0;
      end else begin
         if (csr_we) begin
            if (csr_addr < REG_WIN_BASE)
               tolerance[CH_W'(csr_addr - REG_TOL_BASE)] = csr_wdata;
            else
               window_reg[CH_W'(csr_addr - REG_WIN_BASE)] = csr_wdata[WIN_W-1:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_results.size() == 0) begin
               $error("response word with no request outstanding");
               mismatches++;
            end else begin
               want = predicted_results.pop_front();
               check_field("out_channel", want.chan, rsp_tuser[CH_W-1:0]);
               check_field("average_new", want.fresh, rsp_tuser[CH_W]);
               check_field("window_dropped", want.dropped, rsp_tuser[CH_W+1]);
               check_field("average", want.average, rsp_tdata[AVG_W-1:0]);
               check_field("power", want.power, rsp_tdata[AVG_W +: POWER_W]);
            end
         end
         if (req_tvalid && req_tready)
            predicted_results.push_back(average_step(req_tuser, req_tdata[SAMPLE_W-1:0]));
      end
      outstanding = predicted_results.size();
   end

endmodule

@@ test/stable_window_averager_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_window_averager_top_tb
// Drives the stable window averager and gives the verdict.
// ----------------------------------------------------------------------------
// A short directed run covers the sample extremes, zero and full tolerance,
// saturated window lengths, half-up rounding, dropped windows and a window
// shortened mid-way. Random phases follow, each with its own tolerances and
// window lengths, mostly stable sample walks with some tolerance breaks and
// noise. Both sides idle in random bursts, the receiver once holds off long
// enough to stall the input, and the last phase runs without idling.
// ----------------------------------------------------------------------------
module stable_window_averager_top_tb
   import swa_pkg::*;
();

   localparam int HOLD_CYCLES = 250;
   localparam int PHASES      = 6;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatches;
   int outstanding;

   logic [TOL_W-1:0]      tol_set [CHANNELS];
   logic [CSR_DATA_W-1:0] win_set [CHANNELS];
   logic [SAMPLE_W-1:0]   walk [CHANNELS];
   int  send_idle_pct;
   int  rsp_idle_pct;
   bit  hold_req = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   stable_window_averager_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   stable_window_averager_checker check_unit (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   task automatic send_word(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] s);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= ch;
      req_tdata <= s;
      do @(posedge clock); while (!req_tready);
      walk[ch] = s;
   endtask

   task automatic sender_gap(input int cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // lower valid and wait for every outstanding response word
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic apply_settings();
      drain();
      for (int i = 0; i < CHANNELS; i++) begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_addr <= REG_TOL_BASE + CSR_ADDR_W'(i);
         csr_wdata <= tol_set[i];
      end
      for (int i = 0; i < CHANNELS; i++) begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_addr <= REG_WIN_BASE + CSR_ADDR_W'(i);
         csr_wdata <= win_set[i];
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_paced(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] s);
      if (!hold_req && $urandom_range(0, 99) < send_idle_pct)
         sender_gap($urandom_range(1, 19));
      send_word(ch, s);
   endtask

   function automatic logic [TOL_W-1:0] pick_tolerance();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return TOL_W'($urandom_range(1, 30));
         2: return '1;
         default: return TOL_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_window();
      case ($urandom_range(0, 11))
         0: return CSR_DATA_W'($urandom_range(0, 1));
         1: return CSR_DATA_W'($urandom_range(0, 65535));
         default: return CSR_DATA_W'($urandom_range(2, 12));
      endcase
   endfunction

   // mostly a stable walk from the last sent sample, some breaks and noise
   function automatic logic [SAMPLE_W-1:0] next_sample(input int ch);
      int unsigned tol;
      int unsigned base;
      int unsigned step;
      int unsigned roll;
      tol = 32'(tol_set[ch]);
      base = 32'(walk[ch]);
      roll = $urandom_range(0, 99);
      if (roll < 6)
         return SAMPLE_W'($urandom_range(0, 65535));
      if (roll < 14) begin
         step = tol + 1 + $urandom_range(0, 20);
         if (base + step <= 65535) return SAMPLE_W'(base + step);
         if (base >= tol + 1) return SAMPLE_W'(base - tol - 1);
         return SAMPLE_W'($urandom_range(0, 65535));
      end
      step = (roll < 22) ? tol : $urandom_range(0, (tol > 400) ? 400 : tol);
      if ($urandom_range(0, 1) && base + step <= 65535) return SAMPLE_W'(base + step);
      if (base >= step) return SAMPLE_W'(base - step);
      return (base + step > 65535) ? 16'hFFFF : SAMPLE_W'(base + step);
   endfunction

   initial begin : receiver
      int burst;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else if ($urandom_range(0, 99) < rsp_idle_pct) begin
            burst = $urandom_range(1, 19);
            rsp_tready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int count;
      int favorite;
      int fav_pct;
      int ch;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      send_idle_pct = 15;
      rsp_idle_pct = 5;
      for (int i = 0; i < CHANNELS; i++) walk[i] = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed: zero and full tolerance, window registers 0 and 1 saturate to 2
      tol_set = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd1};
      win_set = '{16'd2, 16'd0, 16'd1, 16'd4};
      apply_settings();
      send_paced(2'd3, 16'd7);
      send_paced(2'd3, 16'd7);
      send_paced(2'd3, 16'd7);
      send_paced(2'd0, 16'd0);
      send_paced(2'd0, 16'd0);
      send_paced(2'd0, 16'hFFFF);
      send_paced(2'd0, 16'hFFFF);
      send_paced(2'd0, 16'd5);
      send_paced(2'd0, 16'd6);
      send_paced(2'd1, 16'hFFFF);
      send_paced(2'd1, 16'd0);
      send_paced(2'd2, 16'hFFFF);
      send_paced(2'd2, 16'hFFFF);
      send_paced(2'd1, 16'hFFFF);
      send_paced(2'd1, 16'hFFFF);

      // channel 3 window shortened below its fill, then half-up rounding
      win_set[3] = 16'd2;
      apply_settings();
      send_paced(2'd3, 16'd7);
      send_paced(2'd3, 16'd5);
      send_paced(2'd3, 16'd5);
      send_paced(2'd3, 16'd4);
      send_paced(2'd3, 16'd5);
      send_paced(2'd3, 16'd3);
      send_paced(2'd3, 16'd5);

      for (int p = 0; p < PHASES; p++) begin
         favorite = $urandom_range(0, 3);
         fav_pct = 25;
         count = 25;
         send_idle_pct = (p == 3) ? 0 : 15;
         rsp_idle_pct = (p == 3) ? 0 : 5;
         case (p)
            0: begin
               // full window on channel 0, high byte of the write ignored
               tol_set = '{16'hFFFF, 16'd40, 16'd0, 16'd500};
               win_set = '{16'hFF80, 16'd3, 16'd2, 16'd5};
               favorite = 0;
               fav_pct = 95;
               count = 150;
            end
            1: begin
               // window register 255 saturates to the largest window
               tol_set = '{16'd5, 16'hFFFF, 16'd100, 16'd1};
               win_set = '{16'd4, 16'd255, 16'd0, 16'd1};
               favorite = 1;
               fav_pct = 95;
               count = 150;
            end
            default: begin
               for (int i = 0; i < CHANNELS; i++) begin
                  tol_set[i] = pick_tolerance();
                  win_set[i] = pick_window();
               end
            end
         endcase
         if (p == PHASES - 1) begin
            send_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         apply_settings();
         for (int k = 0; k < count; k++) begin
            if (p == 2 && k == 0) hold_req = 1'b1;
            if (p == 4 && k == count / 2) drain();
            ch = ($urandom_range(0, 99) < fav_pct) ? favorite : int'($urandom_range(0, 3));
            send_paced(CH_W'(ch), next_sample(ch));
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("stable_window_averager_top_tb: PASS");
      else
         $display("stable_window_averager_top_tb: FAIL");
      $finish;
   end

   initial begin : watchdog
      #8_000_000;
      $display("stable_window_averager_top_tb: FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/swa_pkg.sv
rtl/core/stable_window_averager_top.sv
test/stable_window_averager_checker.sv
test/stable_window_averager_top_tb.sv
